// File: design/bitmap_font_glyph_quad_layout_assert.svh
// Assertion macros for the glyph quad layout block.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BITMAP_FONT_GLYPH_QUAD_LAYOUT_ASSERT_SVH
`define BITMAP_FONT_GLYPH_QUAD_LAYOUT_ASSERT_SVH

`ifndef ASSERT_OFF
`define BFGQL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: assertion failed");
`define BFGQL_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("%m: forbidden condition");
`else
`define BFGQL_ASSERT(lbl, prop)
`define BFGQL_NEVER(lbl, expr)
`endif

`endif

// File: design/bfgql_pkg.sv
// Shared types and constants for the glyph quad layout block.
// No dependencies.
package bfgql_pkg;

	localparam int PEN_BITS = 12;
	localparam int EDGE_BITS = 13;
	localparam int TXT_BITS = 12;
	localparam int CODE_BITS = 8;
	localparam int MET_BITS = 8;
	localparam int MET_DEPTH = 256;
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 4;

	localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [3:0] LINE_STEP = 4'd8;
	localparam logic [PEN_BITS-1:0] PEN_MAX = {PEN_BITS{1'b1}};
	localparam logic [TXT_BITS-1:0] TXT_MAX = {TXT_BITS{1'b1}};

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_CHAR  = 2'd1,
		FUNC_START = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SHADOW_ENABLE = 1'b0,
		CFG_COLOR_CODE    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [CODE_BITS-1:0] addr;
		logic [MET_BITS-1:0]  wdata;
	} ram_req_t;

	typedef struct packed {
		logic                shadow;
		logic [PEN_BITS-1:0] x0;
		logic [PEN_BITS-1:0] y0;
		logic [3:0]          w;
		logic [7:0]          u0;
		logic [6:0]          v0;
		logic [TXT_BITS-1:0] tw;
		logic [TXT_BITS-1:0] th;
	} quad_t;

endpackage

// File: design/bfgql_metrics_ram.sv
// Glyph metrics store: 256 x 8 synchronous RAM, up to one read and one write per cycle.
// Depends on bfgql_pkg.
module bfgql_metrics_ram
	import bfgql_pkg::*;
(
	input  logic                clk,
	input  ram_req_t            req,
	output logic [MET_BITS-1:0] rdata
);

	logic [MET_BITS-1:0] mem [MET_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

// File: design/bfgql_layout.sv
// Read stage and pen state: issues metrics accesses, advances the pen,
// builds one quad description per non-newline character. Depends on bfgql_pkg.
module bfgql_layout
	import bfgql_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [CODE_BITS-1:0] char_code,
	input  logic [MET_BITS-1:0]  glyph_metrics,
	input  logic                 shadow_enable,
	output ram_req_t             ram_req,
	input  logic [MET_BITS-1:0]  ram_rdata,
	input  logic                 emit_free,
	output logic                 quad_load,
	output quad_t                quad
);

	logic                 vld_s1;
	func_t                func_s1;
	logic [CODE_BITS-1:0] code_s1;
	logic [PEN_BITS-1:0]  pen_x_q;
	logic [PEN_BITS-1:0]  pen_y_q;
	logic [PEN_BITS-1:0]  widest_q;

	logic                 accept;
	logic                 is_char;
	logic                 is_nl;
	logic                 adv;
	logic [3:0]           w;
	logic [3:0]           off;
	logic [PEN_BITS:0]    x_sum;
	logic [PEN_BITS:0]    y_sum;
	logic [PEN_BITS-1:0]  x_next;
	logic [PEN_BITS-1:0]  y_next;
	logic [PEN_BITS-1:0]  tw_full;
	logic [PEN_BITS-1:0]  nl_widest;

	assign accept = in_valid && in_ready;
	assign is_char = func_s1 == FUNC_CHAR;
	assign is_nl = code_s1 == NEWLINE_CODE;
	assign adv = vld_s1 && (!(is_char && !is_nl) || emit_free);
	assign in_ready = !vld_s1 || adv;

	always_comb begin
		ram_req.we = accept && (func_t'(func) == FUNC_LOAD);
		ram_req.re = accept && (func_t'(func) == FUNC_CHAR);
		ram_req.addr = char_code;
		ram_req.wdata = glyph_metrics;
	end

	assign w = ram_rdata[3:0];
	assign off = ram_rdata[7:4];
	assign x_sum = {1'b0, pen_x_q} + (PEN_BITS+1)'(w);
	assign y_sum = {1'b0, pen_y_q} + (PEN_BITS+1)'(LINE_STEP);
	assign x_next = x_sum[PEN_BITS] ? PEN_MAX : x_sum[PEN_BITS-1:0];
	assign y_next = y_sum[PEN_BITS] ? PEN_MAX : y_sum[PEN_BITS-1:0];
	assign tw_full = (x_next > widest_q) ? x_next : widest_q;
	assign nl_widest = (pen_x_q > widest_q) ? pen_x_q : widest_q;

	always_comb begin
		quad_load = adv && is_char && !is_nl;
		quad.shadow = shadow_enable;
		quad.x0 = pen_x_q;
		quad.y0 = pen_y_q;
		quad.w = w;
		quad.u0 = {1'b0, code_s1[3:0], 3'b000} + 8'(off);
		quad.v0 = {code_s1[7:4], 3'b000};
		quad.tw = TXT_BITS'(tw_full);
		quad.th = (y_sum > (PEN_BITS+1)'(TXT_MAX)) ? TXT_MAX : TXT_BITS'(y_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(func);
			code_s1 <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
			widest_q <= '0;
		end else if (adv) begin
			unique case (func_s1)
				FUNC_START: begin
					pen_x_q <= '0;
					pen_y_q <= '0;
					widest_q <= '0;
				end
				FUNC_CHAR: begin
					if (is_nl) begin
						widest_q <= nl_widest;
						pen_x_q <= '0;
						pen_y_q <= y_next;
					end else begin
						pen_x_q <= x_next;
					end
				end
				FUNC_LOAD, FUNC_NOP: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/bfgql_emit.sv
// Output stage: holds one character's quads and sends shadow (when enabled) then main.
// Depends on bfgql_pkg.
module bfgql_emit
	import bfgql_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 quad_load,
	input  quad_t                quad,
	output logic                 emit_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 is_shadow,
	output logic [EDGE_BITS-1:0] left,
	output logic [EDGE_BITS-1:0] top,
	output logic [EDGE_BITS-1:0] right,
	output logic [EDGE_BITS-1:0] bottom,
	output logic [7:0]           tex_u0,
	output logic [7:0]           tex_u1,
	output logic [6:0]           tex_v0,
	output logic [TXT_BITS-1:0]  text_width,
	output logic [TXT_BITS-1:0]  text_height,
	output logic                 last
);

	logic  sh_vld_q;
	logic  main_vld_q;
	quad_t quad_q;
	logic  xfer;

	assign out_valid = sh_vld_q || main_vld_q;
	assign xfer = out_valid && out_ready;
	assign emit_free = !out_valid || (xfer && !sh_vld_q);

	always_comb begin
		is_shadow = sh_vld_q;
		last = !sh_vld_q;
		left = EDGE_BITS'(quad_q.x0) + EDGE_BITS'(sh_vld_q);
		top = EDGE_BITS'(quad_q.y0) + EDGE_BITS'(sh_vld_q);
		right = left + EDGE_BITS'(quad_q.w);
		bottom = top + EDGE_BITS'(LINE_STEP);
		tex_u0 = quad_q.u0;
		tex_u1 = quad_q.u0 + 8'(quad_q.w);
		tex_v0 = quad_q.v0;
		text_width = quad_q.tw;
		text_height = quad_q.th;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_vld_q <= 1'b0;
			main_vld_q <= 1'b0;
		end else if (quad_load) begin
			sh_vld_q <= quad.shadow;
			main_vld_q <= 1'b1;
		end else if (xfer) begin
			if (sh_vld_q) begin
				sh_vld_q <= 1'b0;
			end else begin
				main_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (quad_load) begin
			quad_q <= quad;
		end
	end

endmodule

// File: design/bitmap_font_glyph_quad_layout.sv
// Proportional bitmap font layout: input items in, glyph quads out.
// Input channel (in_valid/in_ready) carries func, char_code, glyph_metrics:
// metrics loads, characters, start-of-text commands and no-ops. Output channel
// (out_valid/out_ready) carries one quad per transfer; a character yields a
// shadow quad (when shadow_enable is set) and then the main quad, marked last.
// Loads, newlines, start commands and no-ops yield nothing.
// A character's first quad is offered once the metrics RAM has been read at
// its input transfer edge and the output register has then been loaded.
// Throughput: one item per cycle while no quads are pending; a character
// holds the output register until each of its quads is sent, the single
// output register sending one quad a cycle while out_ready is high. A
// character is taken while the previous one's last quad waits in the output
// register. A stalled receiver holds the quad; the read stage and then
// in_ready back up behind it. Reset clears the pen, the widest line and the
// configuration (shadow on, color 15); the metrics store is not cleared and
// must be loaded before use. Configuration writes via cfg_we take effect at
// once; the user must make them only while the block is idle (not enforced).
// Depends on bfgql_pkg, bfgql_metrics_ram, bfgql_layout, bfgql_emit.
`include "bitmap_font_glyph_quad_layout_assert.svh"

module bitmap_font_glyph_quad_layout
	import bfgql_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [CODE_BITS-1:0]     char_code,
	input  logic [MET_BITS-1:0]      glyph_metrics,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     is_shadow,
	output logic [EDGE_BITS-1:0]     left,
	output logic [EDGE_BITS-1:0]     top,
	output logic [EDGE_BITS-1:0]     right,
	output logic [EDGE_BITS-1:0]     bottom,
	output logic [7:0]               tex_u0,
	output logic [7:0]               tex_u1,
	output logic [6:0]               tex_v0,
	output logic [3:0]               color_index,
	output logic [TXT_BITS-1:0]      text_width,
	output logic [TXT_BITS-1:0]      text_height,
	output logic                     last
);

	logic                shadow_enable_q;
	logic [3:0]          color_code_q;
	ram_req_t            ram_req;
	logic [MET_BITS-1:0] ram_rdata;
	logic                emit_free;
	logic                quad_load;
	quad_t               quad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_enable_q <= 1'b1;
			color_code_q <= 4'hF;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SHADOW_ENABLE: shadow_enable_q <= cfg_data[0];
				CFG_COLOR_CODE:    color_code_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign color_index = color_code_q;

	bfgql_metrics_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	bfgql_layout u_layout (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.char_code     (char_code),
		.glyph_metrics (glyph_metrics),
		.shadow_enable (shadow_enable_q),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata),
		.emit_free     (emit_free),
		.quad_load     (quad_load),
		.quad          (quad)
	);

	bfgql_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.quad_load   (quad_load),
		.quad        (quad),
		.emit_free   (emit_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_shadow   (is_shadow),
		.left        (left),
		.top         (top),
		.right       (right),
		.bottom      (bottom),
		.tex_u0      (tex_u0),
		.tex_u1      (tex_u1),
		.tex_v0      (tex_v0),
		.text_width  (text_width),
		.text_height (text_height),
		.last        (last)
	);

	`BFGQL_ASSERT(a_shadow_then_main,
		out_valid && out_ready && is_shadow |=> out_valid && !is_shadow)
	`BFGQL_ASSERT(a_shadow_offset,
		out_valid && out_ready && is_shadow |=> left == $past(left) - 13'd1)
	`BFGQL_NEVER(a_load_when_busy, quad_load && !emit_free)

endmodule

// File: dv/bitmap_font_glyph_quad_layout_chk.sv
`timescale 1ns / 100ps
// Checker for the glyph quad layout block: watches the config port and both channels,
// predicts the quads of each character and compares every quad transfer field by field.
// Depends on bfgql_pkg.
module bitmap_font_glyph_quad_layout_chk
	import bfgql_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [1:0]               func,
	input  logic [CODE_BITS-1:0]     char_code,
	input  logic [MET_BITS-1:0]      glyph_metrics,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     is_shadow,
	input  logic [EDGE_BITS-1:0]     left,
	input  logic [EDGE_BITS-1:0]     top,
	input  logic [EDGE_BITS-1:0]     right,
	input  logic [EDGE_BITS-1:0]     bottom,
	input  logic [7:0]               tex_u0,
	input  logic [7:0]               tex_u1,
	input  logic [6:0]               tex_v0,
	input  logic [3:0]               color_index,
	input  logic [TXT_BITS-1:0]      text_width,
	input  logic [TXT_BITS-1:0]      text_height,
	input  logic                     last,
	output int                       quads_owed,
	output int                       mismatches
);

	typedef struct packed {
		logic                 is_shadow;
		logic [EDGE_BITS-1:0] left;
		logic [EDGE_BITS-1:0] top;
		logic [EDGE_BITS-1:0] right;
		logic [EDGE_BITS-1:0] bottom;
		logic [7:0]           u0;
		logic [7:0]           u1;
		logic [6:0]           v0;
		logic [3:0]           color;
		logic [TXT_BITS-1:0]  tw;
		logic [TXT_BITS-1:0]  th;
		logic                 last;
	} glyph_quad_t;

	logic                shadow_on;
	logic [3:0]          ink;
	logic [PEN_BITS-1:0] pen_x;
	logic [PEN_BITS-1:0] pen_y;
	logic [PEN_BITS-1:0] widest;
	logic [MET_BITS-1:0] glyph_table [MET_DEPTH];
	glyph_quad_t         owed[$];

	initial mismatches = 0;

	function automatic logic [PEN_BITS-1:0] pen_step(logic [PEN_BITS-1:0] a, logic [3:0] b);
		logic [PEN_BITS:0] s;
		s = {1'b0, a} + b;
		return s[PEN_BITS] ? PEN_MAX : s[PEN_BITS-1:0];
	endfunction

	function automatic void note_field(string name, logic [15:0] want, logic [15:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	task automatic lay_out_glyph(logic [CODE_BITS-1:0] code);
		glyph_quad_t         q;
		logic [3:0]          w;
		logic [7:0]          u0;
		logic [PEN_BITS-1:0] x0;
		logic [PEN_BITS-1:0] y0;
		w = glyph_table[code][3:0];
		u0 = {code[3:0], 3'b000} + glyph_table[code][7:4];
		x0 = pen_x;
		y0 = pen_y;
		pen_x = pen_step(pen_x, w);
		q.tw = (pen_x > widest) ? pen_x : widest;
		q.th = pen_step(y0, LINE_STEP);
		q.color = ink;
		q.u0 = u0;
		q.u1 = u0 + w;
		q.v0 = {code[7:4], 3'b000};
		if (shadow_on) begin
			q.is_shadow = 1'b1;
			q.left = x0 + 13'd1;
			q.top = y0 + 13'd1;
			q.right = x0 + 13'd1 + w;
			q.bottom = y0 + 13'd9;
			q.last = 1'b0;
			owed.push_back(q);
		end
		q.is_shadow = 1'b0;
		q.left = x0;
		q.top = y0;
		q.right = x0 + w;
		q.bottom = y0 + 13'd8;
		q.last = 1'b1;
		owed.push_back(q);
	endtask

	task automatic check_quad();
		glyph_quad_t want;
		glyph_quad_t got;
		got = '{is_shadow, left, top, right, bottom, tex_u0, tex_u1, tex_v0, color_index,
			text_width, text_height, last};
		if (owed.size() == 0) begin
			$display("%0t: quad transfer expected none, got %p", $time, got);
			mismatches++;
		end else begin
			want = owed.pop_front();
			note_field("is_shadow", want.is_shadow, got.is_shadow);
			note_field("left", want.left, got.left);
			note_field("top", want.top, got.top);
			note_field("right", want.right, got.right);
			note_field("bottom", want.bottom, got.bottom);
			note_field("tex_u0", want.u0, got.u0);
			note_field("tex_u1", want.u1, got.u1);
			note_field("tex_v0", want.v0, got.v0);
			note_field("color_index", want.color, got.color);
			note_field("text_width", want.tw, got.tw);
			note_field("text_height", want.th, got.th);
			note_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_on = 1'b1;
			ink = 4'hF;
			pen_x = '0;
			pen_y = '0;
			widest = '0;
			owed.delete();
		end else begin
			if (out_valid && out_ready)
				check_quad();
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHADOW_ENABLE: shadow_on = cfg_data[0];
					CFG_COLOR_CODE: ink = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (func)
					FUNC_LOAD: glyph_table[char_code] = glyph_metrics;
					FUNC_CHAR: begin
						if (char_code == NEWLINE_CODE) begin
							if (pen_x > widest)
								widest = pen_x;
							pen_x = '0;
							pen_y = pen_step(pen_y, LINE_STEP);
						end else begin
							lay_out_glyph(char_code);
						end
					end
					FUNC_START: begin
						pen_x = '0;
						pen_y = '0;
						widest = '0;
					end
					default: ;
				endcase
			end
		end
		quads_owed <= owed.size();
	end

endmodule

// File: dv/bitmap_font_glyph_quad_layout_tb.sv
`timescale 1ns / 100ps
// Top of the glyph quad layout testbench: clock, reset, text stimulus and output stalls.
// Depends on bfgql_pkg, bitmap_font_glyph_quad_layout and bitmap_font_glyph_quad_layout_chk.
module bitmap_font_glyph_quad_layout_tb;
	import bfgql_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               func = '0;
	logic [CODE_BITS-1:0]     char_code = '0;
	logic [MET_BITS-1:0]      glyph_metrics = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     is_shadow;
	logic [EDGE_BITS-1:0]     left;
	logic [EDGE_BITS-1:0]     top;
	logic [EDGE_BITS-1:0]     right;
	logic [EDGE_BITS-1:0]     bottom;
	logic [7:0]               tex_u0;
	logic [7:0]               tex_u1;
	logic [6:0]               tex_v0;
	logic [3:0]               color_index;
	logic [TXT_BITS-1:0]      text_width;
	logic [TXT_BITS-1:0]      text_height;
	logic                     last;
	int                       quads_owed;
	int                       mismatches;

	logic                     calm = 1'b0;
	logic                     hold_req = 1'b0;
	logic                     loaded [MET_DEPTH];
	logic [CODE_BITS-1:0]     loaded_codes[$];

	bitmap_font_glyph_quad_layout dut (.*);
	bitmap_font_glyph_quad_layout_chk chk (.*);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("bitmap_font_glyph_quad_layout test failed");
		$finish;
	end

	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic send_item(func_t f, logic [CODE_BITS-1:0] c, logic [MET_BITS-1:0] g);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_code <= c;
		glyph_metrics <= g;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (f == FUNC_LOAD && !loaded[c]) begin
			loaded[c] = 1'b1;
			loaded_codes.push_back(c);
		end
	endtask

	task automatic put_char();
		send_item(FUNC_CHAR, loaded_codes[$urandom_range(0, loaded_codes.size() - 1)],
			8'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (quads_owed != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_style(logic en, logic [3:0] shade);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHADOW_ENABLE;
		cfg_data <= {3'($urandom), en};
		@(posedge clk);
		cfg_index <= CFG_COLOR_CODE;
		cfg_data <= shade;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_text(int n);
		int done;
		int r;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_item(FUNC_LOAD, 8'($urandom), 8'($urandom));
			end else if (r < 8) begin
				send_item(FUNC_START, 8'($urandom), 8'($urandom));
			end else if (r < 10) begin
				send_item(FUNC_NOP, 8'($urandom), 8'($urandom));
				continue;
			end else if (r < 22) begin
				send_item(FUNC_CHAR, NEWLINE_CODE, 8'($urandom));
			end else begin
				put_char();
			end
			done++;
		end
	endtask

	task automatic long_line();
		logic [CODE_BITS-1:0] wide;
		wide = {4'($urandom), 4'hE};
		send_item(FUNC_START, 8'($urandom), 8'($urandom));
		send_item(FUNC_LOAD, wide, {4'($urandom), 4'hF});
		repeat (285) send_item(FUNC_CHAR, wide, 8'($urandom));
		send_item(FUNC_CHAR, NEWLINE_CODE, 8'($urandom));
		repeat (4) put_char();
	endtask

	task automatic tall_text();
		send_item(FUNC_START, 8'($urandom), 8'($urandom));
		repeat (515) begin
			send_item(FUNC_CHAR, NEWLINE_CODE, 8'($urandom));
			if ($urandom_range(0, 19) == 0)
				put_char();
		end
		repeat (6) put_char();
	endtask

	initial begin
		foreach (loaded[i])
			loaded[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(FUNC_LOAD, 8'h00, 8'h00);
		send_item(FUNC_LOAD, 8'hFF, 8'hFF);
		send_item(FUNC_LOAD, 8'h41, 8'h5A);
		send_item(FUNC_LOAD, NEWLINE_CODE, 8'h37);
		send_item(FUNC_LOAD, 8'h80, 8'hF1);
		send_item(FUNC_CHAR, 8'h00, 8'h00);
		send_item(FUNC_CHAR, 8'hFF, 8'hFF);
		send_item(FUNC_CHAR, 8'h41, 8'h00);
		send_item(FUNC_CHAR, 8'h80, 8'h00);
		send_item(FUNC_CHAR, NEWLINE_CODE, 8'hFF);
		send_item(FUNC_CHAR, 8'h41, 8'h00);
		send_item(FUNC_NOP, 8'hAA, 8'h55);
		send_item(FUNC_CHAR, 8'hFF, 8'h00);
		send_item(FUNC_CHAR, NEWLINE_CODE, 8'h00);
		send_item(FUNC_START, 8'hFF, 8'hFF);
		send_item(FUNC_CHAR, 8'h41, 8'h00);
		send_item(FUNC_LOAD, 8'h41, 8'hA5);
		send_item(FUNC_CHAR, 8'h41, 8'h00);
		send_item(FUNC_CHAR, NEWLINE_CODE, 8'h00);
		send_item(FUNC_CHAR, NEWLINE_CODE, 8'h00);
		send_item(FUNC_CHAR, 8'h00, 8'h00);
		drain();

		set_style(1'b0, 4'h0);
		repeat (16) send_item(FUNC_LOAD, 8'($urandom), 8'($urandom));
		run_text(120);
		drain();

		set_style(1'b1, 4'hF);
		hold_req = 1'b1;
		run_text(120);
		drain();

		set_style(1'b1, 4'h0);
		long_line();
		drain();

		set_style(1'b1, 4'($urandom));
		tall_text();
		drain();

		set_style(1'b0, 4'hF);
		run_text(180);
		drain();

		set_style(1'($urandom), 4'($urandom));
		run_text(200);
		drain();

		calm = 1'b1;
		set_style(1'b1, 4'($urandom));
		run_text(120);
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && quads_owed == 0) begin
			$display("bitmap_font_glyph_quad_layout test passed");
		end else begin
			$display("bitmap_font_glyph_quad_layout test failed");
		end
		$finish;
	end

endmodule

// File: bitmap_font_glyph_quad_layout.f
+incdir+design
design/bfgql_pkg.sv
design/bfgql_metrics_ram.sv
design/bfgql_layout.sv
design/bfgql_emit.sv
design/bitmap_font_glyph_quad_layout.sv
dv/bitmap_font_glyph_quad_layout_chk.sv
dv/bitmap_font_glyph_quad_layout_tb.sv
